@@ hdl/cme_pkg.sv @@
// shared types and constants of the counter machine executor
`timescale 1ns / 1ps

package cme_pkg;

    // highest usable program length, longer settings count as this
    localparam int C_PROGRAM_DEPTH = 1024;

    // request kinds
    localparam logic [1:0] OP_EXEC    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_SPARE   = 2'd3;

    // instruction kinds
    localparam logic [1:0] INS_INC  = 2'd0;
    localparam logic [1:0] INS_DEC  = 2'd1;
    localparam logic [1:0] INS_GOTO = 2'd2;
    localparam logic [1:0] INS_STOP = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] opcode;
        logic [7:0] counter_addr;
        logic [9:0] jump_target;
    } t_in_item;

    typedef struct packed {
        logic [10:0] next_pc;
        logic        halted;
        logic        finished;
        logic [31:0] counter_value;
        logic        overflow;
        logic        ignored;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic rd_en;
        logic exec;
        logic clr_en;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic restart;
        logic clr_last;
    } t_dp_status;

endpackage

@@ hdl/cme_datapath.sv @@
// datapath: counter memory, program counter, halt flag, program length, result register
`timescale 1ns / 1ps

module cme_datapath #(
    parameter int NUM_COUNTERS  = 256,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cme_pkg::t_ctl_cmd  i_cmd,
    output cme_pkg::t_dp_status o_sts,
    input  cme_pkg::t_in_item  i_in_data,
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_data,
    output cme_pkg::t_out_item o_out_data
);

    localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

    // address modulo counter count, restoring steps against a constant divisor
    function automatic logic [IDX_W-1:0] f_wrap_addr(input logic [7:0] addr);
        logic [7:0] r;
        r = addr;
        for (int k = 7; k >= 0; k--) begin
            if (32'(r) >= (32'(NUM_COUNTERS) << k)) begin
                r = r - 8'(32'(NUM_COUNTERS) << k);
            end
        end
        return IDX_W'(r);
    endfunction

    logic [COUNTER_WIDTH-1:0] r_mem [NUM_COUNTERS];
    logic [COUNTER_WIDTH-1:0] r_rd_data;

    cme_pkg::t_in_item  r_item;
    logic [IDX_W-1:0]   r_idx;
    logic [10:0]        r_pc, n_pc;
    logic               r_halt, n_halt;
    logic [10:0]        r_len;
    logic [IDX_W-1:0]   r_clr_addr;
    cme_pkg::t_out_item r_out, n_out;

    logic                     wr;
    logic [COUNTER_WIDTH-1:0] wdata;
    logic [COUNTER_WIDTH-1:0] val;
    logic                     ovf, ign, fin_now;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_wa;
    logic [COUNTER_WIDTH-1:0] mem_wd;

    assign fin_now = r_halt || (r_pc >= r_len) || (32'(r_pc) >= 32'(cme_pkg::C_PROGRAM_DEPTH));

    always_comb begin
        n_pc   = r_pc;
        n_halt = r_halt;
        wr     = 1'b0;
        wdata  = r_rd_data;
        val    = r_rd_data;
        ovf    = 1'b0;
        ign    = 1'b0;
        case (r_item.op)
            cme_pkg::OP_RESTART: begin
                n_pc   = '0;
                n_halt = 1'b0;
                val    = '0;
            end
            cme_pkg::OP_EXEC: begin
                if (fin_now) begin
                    ign = 1'b1;
                end else begin
                    case (r_item.opcode)
                        cme_pkg::INS_INC: begin
                            if (&r_rd_data) begin
                                ovf = 1'b1;
                            end else begin
                                wr    = 1'b1;
                                wdata = r_rd_data + 1'b1;
                                val   = wdata;
                            end
                            n_pc = r_pc + 11'd1;
                        end
                        cme_pkg::INS_DEC: begin
                            if (|r_rd_data) begin
                                wr    = 1'b1;
                                wdata = r_rd_data - 1'b1;
                                val   = wdata;
                                n_pc  = r_pc + 11'd1;
                            end else begin
                                n_pc = {1'b0, r_item.jump_target};
                            end
                        end
                        cme_pkg::INS_GOTO: begin
                            n_pc = {1'b0, r_item.jump_target};
                        end
                        default: begin
                            n_halt = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        n_out.next_pc       = n_pc;
        n_out.halted        = n_halt;
        n_out.finished      = n_halt || (n_pc >= r_len)
                              || (32'(n_pc) >= 32'(cme_pkg::C_PROGRAM_DEPTH));
        n_out.counter_value = 32'(val);
        n_out.overflow      = ovf;
        n_out.ignored       = ign;
    end

    // memory write: clearing sweep or counter update
    assign mem_we = i_cmd.clr_en || (i_cmd.exec && wr);
    assign mem_wa = i_cmd.clr_en ? r_clr_addr : r_idx;
    assign mem_wd = i_cmd.clr_en ? '0 : wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
            r_idx  <= f_wrap_addr(i_in_data.counter_addr);
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_halt     <= 1'b0;
            r_len      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_pc   <= n_pc;
                r_halt <= n_halt;
            end
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            if (i_cmd.clr_en) begin
                r_clr_addr <= o_sts.clr_last ? '0 : r_clr_addr + 1'b1;
            end
        end
    end

    assign o_sts.restart  = (r_item.op == cme_pkg::OP_RESTART);
    assign o_sts.clr_last = (r_clr_addr == IDX_W'(NUM_COUNTERS - 1));
    assign o_out_data     = r_out;

endmodule

@@ hdl/cme_ctrl.sv @@
// controller: sequencing of clear sweep, read, execute and result handoff
`timescale 1ns / 1ps

module cme_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  cme_pkg::t_dp_status i_sts,
    output cme_pkg::t_ctl_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.restart ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec && i_sts.restart |=> r_state == S_CLEAR)
        else $error("restart did not start clearing sweep");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while full");

    a_read_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_state == S_EXEC)
        else $error("read not followed by execute");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("pending result dropped");

endmodule

@@ hdl/counter_machine_executor.sv @@
// top level of the counter machine executor
`timescale 1ns / 1ps
// an accepted request is loaded, then its counter is read via the registered read port;
//   execute then updates it through the single write port and registers the result
//   with valid raised, waiting while a result is unread; the next request is taken
//   only after that execute; a restart adds a sweep clearing all NUM_COUNTERS counters
//   with ready low. reset (synchronous, active low): pc, halt flag and program length
//   to zero, then the same sweep zeroes the counters before the first request

module counter_machine_executor #(
    parameter int NUM_COUNTERS  = 256,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cme_pkg::t_in_item  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cme_pkg::t_out_item o_out_data,
    // program length register write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [10:0]        i_cfg_data
);

    cme_pkg::t_ctl_cmd   cmd;
    cme_pkg::t_dp_status sts;

    // program length can be written at any time the port is valid
    assign o_cfg_ready = 1'b1;

    // sequencer: sweep, accept, read, execute, hand off result
    cme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // counter memory, pc, halt flag and the result register
    cme_datapath #(
        .NUM_COUNTERS  (NUM_COUNTERS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

endmodule

@@ verif/tb_counter_machine_executor.sv @@
// self-checking testbench of the counter machine executor
`timescale 1ns / 1ps

module tb_counter_machine_executor;

    localparam int NUM_CNT    = 256;
    localparam int IDLE_LIMIT = 4000;   // restart sweep plus worst stalls, many times over

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    cme_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    cme_pkg::t_out_item o_out_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [10:0]        i_cfg_data;

    counter_machine_executor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the machine: counters, pc, halt flag and program length,
    // plus the outcomes still owed by the block in request order
    class machine_shadow;
        logic [31:0]        counter_val [NUM_CNT];
        logic [10:0]        pc;
        logic               halt;
        logic [10:0]        prog_len;
        cme_pkg::t_out_item pending [$];
        int                 errors, n_exec, n_ignored, n_restart, n_read, n_checked;

        function new();
            foreach (counter_val[i]) counter_val[i] = '0;
            pc       = '0;
            halt     = 1'b0;
            prog_len = '0;
        endfunction

        function int effective_length();
            return (prog_len > cme_pkg::C_PROGRAM_DEPTH) ? cme_pkg::C_PROGRAM_DEPTH
                                                         : int'(prog_len);
        endfunction

        function bit is_done();
            return halt || (int'(pc) >= effective_length());
        endfunction

        function void set_length(logic [10:0] len);
            prog_len = len;
        endfunction

        // apply one accepted request and queue the outcome it must produce
        function void step_request(cme_pkg::t_in_item req);
            cme_pkg::t_out_item outcome;
            logic [31:0]        cur;
            outcome = '0;
            cur = counter_val[req.counter_addr];
            case (req.op)
                cme_pkg::OP_RESTART: begin
                    foreach (counter_val[i]) counter_val[i] = '0;
                    pc   = '0;
                    halt = 1'b0;
                    n_restart++;
                end
                cme_pkg::OP_EXEC: begin
                    if (is_done()) begin
                        outcome.ignored = 1'b1;
                        n_ignored++;
                    end else begin
                        n_exec++;
                        case (req.opcode)
                            cme_pkg::INS_INC: begin
                                // saturate at full scale instead of wrapping
                                if (cur == '1)
                                    outcome.overflow = 1'b1;
                                else
                                    counter_val[req.counter_addr] = cur + 32'd1;
                                pc = pc + 11'd1;
                            end
                            cme_pkg::INS_DEC: begin
                                if (cur != '0) begin
                                    counter_val[req.counter_addr] = cur - 32'd1;
                                    pc = pc + 11'd1;
                                end else begin
                                    pc = {1'b0, req.jump_target};
                                end
                            end
                            cme_pkg::INS_GOTO: pc = {1'b0, req.jump_target};
                            default:  halt = 1'b1;   // stop keeps pc in place
                        endcase
                    end
                end
                default: n_read++;   // read, and the unused op code, change nothing
            endcase
            outcome.next_pc       = pc;
            outcome.halted        = halt;
            outcome.finished      = is_done();
            outcome.counter_value = counter_val[req.counter_addr];
            pending = {pending, outcome};
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(cme_pkg::t_out_item got);
            cme_pkg::t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing outstanding, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            compare_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
            compare_field("halted", 32'(want.halted), 32'(got.halted));
            compare_field("finished", 32'(want.finished), 32'(got.finished));
            compare_field("counter_value", want.counter_value, got.counter_value);
            compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
            compare_field("ignored", 32'(want.ignored), 32'(got.ignored));
        endfunction
    endclass

    machine_shadow sb;

    // instruction memory the testbench fetches from, indexed by the predicted pc
    cme_pkg::t_in_item program_mem [cme_pkg::C_PROGRAM_DEPTH];
    int       steps_left = 0;    // requests left in the current run of the program
    int       burst_left = 0;    // requests left in the current sender burst
    int       idle_cycles = 0;
    int       stall_timer = 0;
    int       stall_mode = 0;

    // free-running clock, 8 ns period
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: check every accepted result, stall on a pattern that
    // switches between always ready, random, sparse and alternating
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
        if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(16, 80);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= (stall_timer % 8 == 0);
            default: i_out_ready <= ~i_out_ready;
        endcase
    end

    // watchdog: count cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic cme_pkg::t_in_item random_request();
        cme_pkg::t_in_item req;
        req.op           = 2'($urandom_range(0, 3));
        req.opcode       = 2'($urandom_range(0, 3));
        req.counter_addr = 8'($urandom_range(0, 255));
        req.jump_target  = 10'($urandom_range(0, 1023));
        return req;
    endfunction

    function automatic cme_pkg::t_in_item make_request(logic [1:0] op, logic [1:0] opcode,
                                                       logic [7:0] addr, logic [9:0] target);
        cme_pkg::t_in_item req;
        req.op           = op;
        req.opcode       = opcode;
        req.counter_addr = addr;
        req.jump_target  = target;
        return req;
    endfunction

    // fresh random program over the current length; counters come mostly from a
    // few low and high addresses so that dec sees both zero and nonzero values
    function automatic void load_program();
        int len;
        int r;
        len = sb.effective_length();
        for (int i = 0; i < len; i++) begin
            program_mem[i]    = random_request();
            program_mem[i].op = cme_pkg::OP_EXEC;
            r = $urandom_range(0, 99);
            program_mem[i].opcode = (r < 40) ? cme_pkg::INS_INC :
                                    (r < 75) ? cme_pkg::INS_DEC :
                                    (r < 90) ? cme_pkg::INS_GOTO : cme_pkg::INS_STOP;
            r = $urandom_range(0, 99);
            if (r < 70)
                program_mem[i].counter_addr = 8'($urandom_range(0, 3));
            else if (r < 85)
                program_mem[i].counter_addr = 8'($urandom_range(252, 255));
            // mostly land inside the program, now and then anywhere
            if ($urandom_range(0, 9) != 0)
                program_mem[i].jump_target = 10'($urandom_range(0, len - 1));
        end
    endfunction

    // mostly runs of a program from a restart: fetch at the predicted pc until
    // finished, poke the finished machine a little, then restart; some noise
    function automatic cme_pkg::t_in_item next_request();
        cme_pkg::t_in_item req;
        int                r;
        req = random_request();
        if (steps_left == 0) begin
            load_program();
            req.op     = cme_pkg::OP_RESTART;
            steps_left = $urandom_range(4, 40);
            return req;
        end
        steps_left--;
        r = $urandom_range(0, 99);
        if (r < 80 && !sb.is_done()) begin
            req = program_mem[sb.pc[9:0]];
        end else if (r < 80) begin
            req.op = $urandom_range(0, 1) ? cme_pkg::OP_EXEC : cme_pkg::OP_READ;
            if (steps_left > 2)
                steps_left = 2;
        end
        return req;
    endfunction

    // present one request; the sender works in bursts with gaps between them
    task automatic send_request(input cme_pkg::t_in_item req);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.step_request(req);
        burst_left--;
        if (burst_left == 0)
            i_in_valid <= 1'b0;
    endtask

    // drop valid after the last request of a phase
    task automatic end_burst();
        if (burst_left != 0) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    // length is only written with no request or result outstanding
    task automatic write_length(input logic [10:0] len);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_length(len);
    endtask

    // extremes of the fields, every instruction and the corner behaviors;
    // saturation of a counter would need 2^32 increments and is out of reach
    task automatic run_directed();
        // zero length: execute is ignored, read and the unused op do nothing
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_INC, 8'd0, 10'd0));
        send_request(make_request(cme_pkg::OP_READ, cme_pkg::INS_INC, 8'd255, 10'd0));
        send_request(make_request(cme_pkg::OP_SPARE, cme_pkg::INS_STOP, 8'd0, 10'd1023));
        end_burst();
        write_length(11'd8);
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_INC, 8'd0, 10'd0));
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_INC, 8'd255, 10'd1023));
        // dec of a nonzero counter, then of a zero counter which jumps
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_DEC, 8'd0, 10'd1023));
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_DEC, 8'd0, 10'd5));
        send_request(make_request(cme_pkg::OP_READ, cme_pkg::INS_DEC, 8'd255, 10'd0));
        // jump past the end finishes the run, further execute is ignored
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_GOTO, 8'd1, 10'd1023));
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_INC, 8'd1, 10'd0));
        send_request(make_request(cme_pkg::OP_RESTART, cme_pkg::INS_STOP, 8'd255, 10'd1023));
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_GOTO, 8'd255, 10'd0));
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_INC, 8'd3, 10'd0));
        // stop halts with pc held, then execute is ignored
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_STOP, 8'd3, 10'd0));
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_GOTO, 8'd3, 10'd2));
        send_request(make_request(cme_pkg::OP_READ, cme_pkg::INS_STOP, 8'd3, 10'd0));
        send_request(make_request(cme_pkg::OP_RESTART, cme_pkg::INS_INC, 8'd0, 10'd0));
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_DEC, 8'd128, 10'd7));
        send_request(make_request(cme_pkg::OP_EXEC, cme_pkg::INS_INC, 8'd128, 10'd0));
        send_request(make_request(cme_pkg::OP_SPARE, cme_pkg::INS_GOTO, 8'd128, 10'd512));
        end_burst();
    endtask

    initial begin : stimulus
        logic [10:0] lengths [10];
        sb = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        // short programs mostly, plus zero length, the full depth, the all-ones setting
        // and a setting above the depth
        lengths[0] = 11'd1;
        lengths[1] = 11'd2;
        lengths[2] = 11'($urandom_range(3, 16));
        lengths[3] = 11'($urandom_range(17, 64));
        lengths[4] = 11'd1024;
        lengths[5] = 11'd2047;
        lengths[6] = 11'($urandom_range(1025, 2046));
        lengths[7] = 11'd0;
        lengths[8] = 11'($urandom_range(3, 16));
        lengths[9] = 11'd8;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int p = 0; p < 10; p++) begin
            write_length(lengths[p]);
            steps_left = 0;
            repeat (40) send_request(next_request());
            end_burst();
        end

        // drain, then give the block time to show any stray result
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d executed instructions, %0d ignored executes, %0d reads,",
                 sb.n_exec, sb.n_ignored, sb.n_read);
        $display("%0d restarts across twelve program length settings; %0d results checked",
                 sb.n_restart, sb.n_checked);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
